>>> rtl/core/imsd_pkg.sv
`default_nettype none

package imsd_pkg;

  localparam int unsigned IMSD_FRAC_BITS = 8;

  localparam logic [17:0] RATE_MAX      = 18'd262143;
  localparam logic [21:0] DRAIN_MAX     = 22'd4194303;
  localparam logic [15:0] INTENSITY_ONE = 16'd32768;

  localparam logic [24:0] GYRO_LSB_PER_DPS = 25'd131;
  localparam logic [24:0] DRAIN_DIVISOR    = 25'd20000000;

  localparam logic [2:0] REG_SURPRISE_RATIO = 3'd0;
  localparam logic [2:0] REG_ALPHA_RISE     = 3'd1;
  localparam logic [2:0] REG_ALPHA_FALL     = 3'd2;
  localparam logic [2:0] REG_HIT_THRESHOLD  = 3'd3;
  localparam logic [2:0] REG_JOLT_GAIN      = 3'd4;

  localparam logic [11:0] RESET_SURPRISE_RATIO = 12'd768;
  localparam logic [15:0] RESET_ALPHA_RISE     = 16'd3277;
  localparam logic [15:0] RESET_ALPHA_FALL     = 16'd13107;
  localparam logic [15:0] RESET_HIT_THRESHOLD  = 16'd256;
  localparam logic [9:0]  RESET_JOLT_GAIN      = 10'd300;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_GSQ,
    ST_GROOT,
    ST_GDIV,
    ST_ASQ,
    ST_AROOT,
    ST_JOLT,
    ST_SCALE,
    ST_EMA,
    ST_NORM,
    ST_LOGSQ,
    ST_LDIV,
    ST_DSQ,
    ST_DCUBE,
    ST_DDIV,
    ST_OUT
  } state_e;

  // Base-two logarithm in Q16, evaluated at elaboration for constant arguments.
  function automatic logic [31:0] log2_q16(input logic [63:0] v);
    logic [5:0]  e;
    logic [63:0] m;
    logic [15:0] frac;
    e    = '0;
    frac = '0;
    for (int k = 1; k < 63; k++) begin
      if ((v >> k) != 64'd0) begin
        e = 6'(k);
      end
    end
    m = v << (6'd30 - e);
    for (int i = 0; i < 16; i++) begin
      m    = (m * m) >> 30;
      frac = {frac[14:0], 1'b0};
      if (m >= 64'h8000_0000) begin
        m       = m >> 1;
        frac[0] = 1'b1;
      end
    end
    return {10'd0, e, frac};
  endfunction

  localparam logic [31:0] LOG2_301_Q16 = log2_q16(64'd301);

endpackage

`default_nettype wire

>>> rtl/core/imu_motion_surprise_detector_top.sv
// Without a hit, an item passes through two bit-serial square roots and one bit-serial
// division by 131.
// A hit adds normalization, sixteen squarings and up to two more serial divisions.
// One item is in work at a time; the next is taken once the result sits in the output
// register.
// Reset clears the baseline to zero and loads the default register values.
`default_nettype none

module imu_motion_surprise_detector_top
  import imsd_pkg::*;
#(
  parameter int unsigned FRAC_BITS = IMSD_FRAC_BITS
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [15:0] accel_x_i,
  input  wire logic [15:0] accel_y_i,
  input  wire logic [15:0] accel_z_i,
  input  wire logic [15:0] gyro_x_i,
  input  wire logic [15:0] gyro_y_i,
  input  wire logic [15:0] gyro_z_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [17:0]      motion_rate_o,
  output logic [17:0]      surprise_o,
  output logic             hit_o,
  output logic [15:0]      hit_intensity_o,
  output logic [21:0]      drain_increment_o,
  output logic [17:0]      baseline_o
);

  localparam int unsigned RAD_W   = 32 + 2 * FRAC_BITS;
  localparam int unsigned ROOT_W  = RAD_W / 2;
  localparam int unsigned DIV_W   = 32 + 2 * FRAC_BITS;
  localparam int unsigned SQ_W    = 20 + FRAC_BITS;
  localparam int unsigned CUBE_W  = 30 + 2 * FRAC_BITS;
  localparam int unsigned SHIFT_W = DIV_W + 16;
  localparam int unsigned DSH_L   = (2 * FRAC_BITS < 16) ? 16 - 2 * FRAC_BITS : 0;
  localparam int unsigned DSH_R   = (2 * FRAC_BITS >= 16) ? 2 * FRAC_BITS - 16 : 0;
  localparam logic [ROOT_W-1:0] ONE_G = ROOT_W'(1) << (14 + FRAC_BITS);
  localparam logic [23:0] SAT_SURPRISE = 24'(1000) << FRAC_BITS;

  state_e state_q, state_d;
  logic   go_q;

  logic [11:0] ratio_q;
  logic [15:0] arise_q, afall_q, thr_q;
  logic [9:0]  gain_q;

  logic [15:0]       axes_q [6];
  logic [3:0]        cnt_q, cnt_d;
  logic [31:0]       acc_q, acc_d;
  logic [ROOT_W-1:0] gyro_q, gyro_d, diff_q, diff_d;
  logic [17:0]       rate_q, rate_d, surp_q, surp_d, base_q, base_d;
  logic              hit_q, hit_d;
  logic [30:0]       m_q, m_d;
  logic [4:0]        e_q, e_d;
  logic [15:0]       frac_q, frac_d, inten_q, inten_d;
  logic [SQ_W-1:0]   sq_q, sq_d;
  logic [CUBE_W-1:0] cube_q, cube_d;
  logic [21:0]       drain_q, drain_d;

  logic [17:0] o_rate_q, o_surp_q, o_base_q;
  logic        o_hit_q;
  logic [15:0] o_inten_q;
  logic [21:0] o_drain_q;
  logic        out_valid_q, out_valid_d, out_load;

  logic [31:0] op_a, op_b;
  logic [63:0] mul_p;
  logic [2:0]  ax_sel;
  logic [15:0] ax_raw, ax_abs;

  logic              sq_start, sq_done;
  logic [ROOT_W-1:0] root;
  logic              dv_start, dv_done;
  logic [DIV_W-1:0]  dv_num, dv_quot, cube3;
  logic [24:0]       dv_den;

  logic              rise, hit_now;
  logic [17:0]       dif;
  logic [63:0]       jolt, gmax, scaled, step, nb;
  logic [SHIFT_W-1:0] dsh;
  logic [20:0]       lv;

  // Configuration port.
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ratio_q <= RESET_SURPRISE_RATIO;
      arise_q <= RESET_ALPHA_RISE;
      afall_q <= RESET_ALPHA_FALL;
      thr_q   <= RESET_HIT_THRESHOLD;
      gain_q  <= RESET_JOLT_GAIN;
    end else if (psel && penable && pwrite) begin
      case (paddr[4:2])
        REG_SURPRISE_RATIO: ratio_q <= pwdata[11:0];
        REG_ALPHA_RISE:     arise_q <= pwdata[15:0];
        REG_ALPHA_FALL:     afall_q <= pwdata[15:0];
        REG_HIT_THRESHOLD:  thr_q   <= pwdata[15:0];
        REG_JOLT_GAIN:      gain_q  <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_SURPRISE_RATIO: prdata = 32'(ratio_q);
      REG_ALPHA_RISE:     prdata = 32'(arise_q);
      REG_ALPHA_FALL:     prdata = 32'(afall_q);
      REG_HIT_THRESHOLD:  prdata = 32'(thr_q);
      REG_JOLT_GAIN:      prdata = 32'(gain_q);
      default:            prdata = '0;
    endcase
  end

  // Serial units.
  assign sq_start = go_q && (state_q == ST_GROOT || state_q == ST_AROOT);
  assign dv_start = go_q && (state_q == ST_GDIV || state_q == ST_LDIV || state_q == ST_DDIV);

  imsd_sqrt #(
    .RAD_W(RAD_W)
  ) u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sq_start),
    .radicand_i (RAD_W'(acc_q) << (2 * FRAC_BITS)),
    .done_o     (sq_done),
    .root_o     (root)
  );

  assign lv    = {e_q - 5'(FRAC_BITS), frac_q};
  assign cube3 = DIV_W'(cube_q) + (DIV_W'(cube_q) << 1);

  always_comb begin
    case (state_q)
      ST_LDIV: begin
        dv_num = DIV_W'({lv, 15'd0});
        dv_den = LOG2_301_Q16[24:0];
      end
      ST_DDIV: begin
        dv_num = cube3;
        dv_den = DRAIN_DIVISOR;
      end
      default: begin
        dv_num = DIV_W'(root);
        dv_den = GYRO_LSB_PER_DPS;
      end
    endcase
  end

  imsd_div #(
    .NUM_W(DIV_W),
    .DEN_W(25)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (dv_start),
    .dividend_i (dv_num),
    .divisor_i  (dv_den),
    .done_o     (dv_done),
    .quot_o     (dv_quot)
  );

  // Shared multiplier.
  assign ax_sel = (state_q == ST_GSQ) ? 3'(cnt_q) + 3'd3 : 3'(cnt_q);
  assign ax_raw = axes_q[ax_sel];
  assign ax_abs = ax_raw[15] ? 16'(-ax_raw) : ax_raw;
  assign rise   = (rate_q > base_q);
  assign dif    = rise ? rate_q - base_q : base_q - rate_q;

  always_comb begin
    case (state_q)
      ST_JOLT: begin
        op_a = 32'(diff_q);
        op_b = 32'(gain_q);
      end
      ST_SCALE: begin
        op_a = 32'(base_q);
        op_b = 32'(ratio_q);
      end
      ST_EMA: begin
        op_a = rise ? 32'(arise_q) : 32'(afall_q);
        op_b = 32'(dif);
      end
      ST_LOGSQ: begin
        op_a = 32'(m_q);
        op_b = 32'(m_q);
      end
      ST_DSQ: begin
        op_a = 32'(surp_q);
        op_b = 32'(surp_q);
      end
      ST_DCUBE: begin
        op_a = 32'(sq_q);
        op_b = 32'(surp_q);
      end
      default: begin
        op_a = 32'(ax_abs);
        op_b = 32'(ax_abs);
      end
    endcase
  end

  assign mul_p = op_a * op_b;

  assign hit_now = ({4'd0, surp_q, 8'd0} > (30'(thr_q) << FRAC_BITS));
  assign jolt    = mul_p >> 14;
  assign gmax    = (64'(gyro_q) > jolt) ? 64'(gyro_q) : jolt;
  assign scaled  = mul_p >> 8;
  assign step    = (mul_p + 64'd32768) >> 16;
  assign nb      = 64'(base_q) + step;
  assign dsh     = (SHIFT_W'(dv_quot) << DSH_L) >> DSH_R;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (in_valid_i) state_d = ST_GSQ;
      ST_GSQ:   if (cnt_q == 4'd2) state_d = ST_GROOT;
      ST_GROOT: if (sq_done) state_d = ST_GDIV;
      ST_GDIV:  if (dv_done) state_d = ST_ASQ;
      ST_ASQ:   if (cnt_q == 4'd2) state_d = ST_AROOT;
      ST_AROOT: if (sq_done) state_d = ST_JOLT;
      ST_JOLT:  state_d = ST_SCALE;
      ST_SCALE: state_d = ST_EMA;
      ST_EMA:   state_d = hit_now ? ST_NORM : ST_OUT;
      ST_NORM:  if (m_q[30]) state_d = ST_LOGSQ;
      ST_LOGSQ: if (cnt_q == 4'd15) state_d = ST_LDIV;
      ST_LDIV:  if (dv_done) state_d = ST_DSQ;
      ST_DSQ:   state_d = ({6'd0, surp_q} >= SAT_SURPRISE) ? ST_OUT : ST_DCUBE;
      ST_DCUBE: state_d = ST_DDIV;
      ST_DDIV:  if (dv_done) state_d = ST_OUT;
      ST_OUT:   if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Datapath and output control.
  assign out_load = (state_q == ST_OUT) && (!out_valid_q || out_ready_i);

  always_comb begin
    cnt_d       = (state_d == state_q) ? cnt_q + 4'd1 : 4'd0;
    acc_d       = acc_q;
    gyro_d      = gyro_q;
    diff_d      = diff_q;
    rate_d      = rate_q;
    surp_d      = surp_q;
    base_d      = base_q;
    hit_d       = hit_q;
    m_d         = m_q;
    e_d         = e_q;
    frac_d      = frac_q;
    inten_d     = inten_q;
    sq_d        = sq_q;
    cube_d      = cube_q;
    drain_d     = drain_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: acc_d = '0;
      ST_GSQ, ST_ASQ: acc_d = acc_q + mul_p[31:0];
      ST_GDIV: begin
        if (dv_done) begin
          gyro_d = dv_quot[ROOT_W-1:0];
          acc_d  = '0;
        end
      end
      ST_AROOT: begin
        if (sq_done) begin
          diff_d = (root > ONE_G) ? root - ONE_G : ONE_G - root;
        end
      end
      ST_JOLT: rate_d = (gmax > 64'(RATE_MAX)) ? RATE_MAX : gmax[17:0];
      ST_SCALE: surp_d = (64'(rate_q) > scaled) ? rate_q - scaled[17:0] : 18'd0;
      ST_EMA: begin
        if (rise) begin
          base_d = (nb > 64'(RATE_MAX)) ? RATE_MAX : nb[17:0];
        end else begin
          base_d = base_q - step[17:0];
        end
        hit_d   = hit_now;
        inten_d = '0;
        drain_d = '0;
        m_d     = 31'(surp_q) + (31'(1) << FRAC_BITS);
        e_d     = 5'd30;
        frac_d  = '0;
      end
      ST_NORM: begin
        if (!m_q[30]) begin
          m_d = m_q << 1;
          e_d = e_q - 5'd1;
        end
      end
      ST_LOGSQ: begin
        frac_d = {frac_q[14:0], mul_p[61]};
        m_d    = mul_p[61] ? mul_p[61:31] : mul_p[60:30];
      end
      ST_LDIV: begin
        if (dv_done) begin
          inten_d = (dv_quot > DIV_W'(INTENSITY_ONE)) ? INTENSITY_ONE : dv_quot[15:0];
        end
      end
      ST_DSQ: begin
        if ({6'd0, surp_q} >= SAT_SURPRISE) begin
          drain_d = DRAIN_MAX;
        end else begin
          sq_d = SQ_W'(mul_p >> FRAC_BITS);
        end
      end
      ST_DCUBE: cube_d = CUBE_W'(mul_p);
      ST_DDIV: begin
        if (dv_done) begin
          drain_d = (dsh > SHIFT_W'(DRAIN_MAX)) ? DRAIN_MAX : dsh[21:0];
        end
      end
      ST_OUT: if (out_load) out_valid_d = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      go_q        <= 1'b0;
      cnt_q       <= '0;
      base_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      go_q        <= (state_d != state_q);
      cnt_q       <= cnt_d;
      base_q      <= base_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_valid_i) begin
      axes_q[0] <= accel_x_i;
      axes_q[1] <= accel_y_i;
      axes_q[2] <= accel_z_i;
      axes_q[3] <= gyro_x_i;
      axes_q[4] <= gyro_y_i;
      axes_q[5] <= gyro_z_i;
    end
    acc_q   <= acc_d;
    gyro_q  <= gyro_d;
    diff_q  <= diff_d;
    rate_q  <= rate_d;
    surp_q  <= surp_d;
    hit_q   <= hit_d;
    m_q     <= m_d;
    e_q     <= e_d;
    frac_q  <= frac_d;
    inten_q <= inten_d;
    sq_q    <= sq_d;
    cube_q  <= cube_d;
    drain_q <= drain_d;
    if (out_load) begin
      o_rate_q  <= rate_q;
      o_surp_q  <= surp_q;
      o_base_q  <= base_q;
      o_hit_q   <= hit_q;
      o_inten_q <= inten_q;
      o_drain_q <= drain_q;
    end
  end

  assign in_ready_o        = (state_q == ST_IDLE);
  assign out_valid_o       = out_valid_q;
  assign motion_rate_o     = o_rate_q;
  assign surprise_o        = o_surp_q;
  assign hit_o             = o_hit_q;
  assign hit_intensity_o   = o_inten_q;
  assign drain_increment_o = o_drain_q;
  assign baseline_o        = o_base_q;

  a_no_hit_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !hit_o) |-> (hit_intensity_o == 16'd0 && drain_increment_o == 22'd0))
    else $error("result without hit carries intensity or drain");

  a_intensity_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (hit_intensity_o <= INTENSITY_ONE))
    else $error("intensity above one");

  a_surprise_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (surprise_o <= motion_rate_o))
    else $error("surprise exceeds motion rate");

  a_sqrt_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_done |-> (state_q == ST_GROOT || state_q == ST_AROOT))
    else $error("root finished outside a root state");

  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_done |-> (state_q == ST_GDIV || state_q == ST_LDIV || state_q == ST_DDIV))
    else $error("division finished outside a division state");

endmodule

`default_nettype wire

>>> rtl/core/imsd_sqrt.sv
`default_nettype none

module imsd_sqrt #(
  parameter int unsigned RAD_W = 48
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic [RAD_W-1:0]   radicand_i,
  output logic                    done_o,
  output logic [RAD_W/2-1:0]      root_o
);

  localparam int unsigned ROOT_W = RAD_W / 2;
  localparam int unsigned CNT_W  = $clog2(ROOT_W + 1);

  logic [RAD_W-1:0]  rad_q, rad_d;
  logic [ROOT_W:0]   rem_q, rem_d;
  logic [ROOT_W-1:0] root_q, root_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;

  logic [ROOT_W+2:0] rem_t, trial, rem_s;
  logic              ge;

  assign rem_t = {rem_q, rad_q[RAD_W-1 -: 2]};
  assign trial = {1'b0, root_q, 2'b01};
  assign rem_s = rem_t - trial;
  assign ge    = (rem_t >= trial);

  always_comb begin
    rad_d  = rad_q;
    rem_d  = rem_q;
    root_d = root_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rad_d  = radicand_i;
      rem_d  = '0;
      root_d = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rad_d  = rad_q << 2;
      rem_d  = ge ? rem_s[ROOT_W:0] : rem_t[ROOT_W:0];
      root_d = {root_q[ROOT_W-2:0], ge};
      cnt_d  = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(ROOT_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

`default_nettype wire

>>> rtl/core/imsd_div.sv
`default_nettype none

module imsd_div #(
  parameter int unsigned NUM_W = 48,
  parameter int unsigned DEN_W = 25
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [NUM_W-1:0] dividend_i,
  input  wire logic [DEN_W-1:0] divisor_i,
  output logic                  done_o,
  output logic [NUM_W-1:0]      quot_o
);

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] sh_q, sh_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [DEN_W-1:0] den_q, den_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;

  logic [DEN_W:0] rem_t, rem_s;
  logic           ge;

  assign rem_t = {rem_q, sh_q[NUM_W-1]};
  assign rem_s = rem_t - {1'b0, den_q};
  assign ge    = (rem_t >= {1'b0, den_q});

  always_comb begin
    sh_d   = sh_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      sh_d   = dividend_i;
      rem_d  = '0;
      den_d  = divisor_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      sh_d  = {sh_q[NUM_W-2:0], ge};
      rem_d = ge ? rem_s[DEN_W-1:0] : rem_t[DEN_W-1:0];
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(NUM_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q  <= sh_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quot_o = sh_q;

endmodule

`default_nettype wire
